[design/i2rd_pkg.sv]
// Package for the integer to radix digit converter.
// Holds field widths and base limits; depends on nothing.
`timescale 1ns / 1ps

package i2rd_pkg;

  localparam int unsigned BaseW  = 6;
  localparam int unsigned PlaceW = 5;
  localparam int unsigned RemW   = BaseW + 1;

  localparam logic [BaseW-1:0] BaseMin = 6'd2;
  localparam logic [BaseW-1:0] BaseMax = 6'd36;

  typedef logic [BaseW-1:0]  base_t;
  typedef logic [PlaceW-1:0] place_t;
  typedef logic [RemW-1:0]   rem_t;

  // Fold an out-of-range base into 2..36.
  function automatic base_t clamp_base(input base_t b);
    base_t r;
    r = b;
    if (b < BaseMin) r = BaseMin;
    if (b > BaseMax) r = BaseMax;
    return r;
  endfunction

endpackage

[design/integer_to_radix_digits.sv]
// Each digit comes from a bit-serial restoring divider that divides the value, then
// each quotient in turn, by the base; the last step of a digit waits while the output
// register is full.
// One value at a time: the next is taken the cycle after the last digit is computed.
// Reset (rst_ni low, asynchronous) returns the block to idle with no digit pending.
`timescale 1ns / 1ps

module integer_to_radix_digits
  import i2rd_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [BaseW-1:0]      target_base_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PlaceW-1:0]     place_o,
  output logic [BaseW-1:0]      digit_o,
  output logic                  last_o
);

  localparam int unsigned CntW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(VALUE_BITS - 1);

  localparam logic StIdle = 1'b0;
  localparam logic StDiv  = 1'b1;

  logic                  state_q, state_d;
  logic [VALUE_BITS-1:0] quo_q, quo_d;
  logic [BaseW-1:0]      rem_q, rem_d;
  base_t                 base_q, base_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  place_t                place_q, place_d;

  logic                  out_valid_q, out_valid_d;
  place_t                out_place_q, out_place_d;
  logic [BaseW-1:0]      out_digit_q, out_digit_d;
  logic                  out_last_q, out_last_d;

  rem_t                  rem_shift;
  logic                  ge;
  rem_t                  rem_sub;
  logic [VALUE_BITS-1:0] quo_step;
  logic                  out_free;
  logic                  step_en;

  assign in_ready_o = (state_q == StIdle);
  assign out_free   = !out_valid_q || out_ready_i;

  // One restoring division step: bring down the next dividend bit.
  assign rem_shift = {rem_q, quo_q[VALUE_BITS-1]};
  assign ge        = (rem_shift >= {1'b0, base_q});
  assign rem_sub   = rem_shift - {1'b0, base_q};
  assign quo_step  = {quo_q[VALUE_BITS-2:0], ge};

  // Stall the last step of a digit while the output register is full.
  assign step_en = (state_q == StDiv) && ((cnt_q != CntLast) || out_free);

  always_comb begin
    state_d     = state_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    base_d      = base_q;
    cnt_d       = cnt_q;
    place_d     = place_q;
    out_valid_d = out_valid_q;
    out_place_d = out_place_q;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;

    // Drop the held digit once its transaction completes.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          quo_d   = value_i;
          rem_d   = '0;
          base_d  = clamp_base(target_base_i);
          cnt_d   = '0;
          place_d = '0;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (step_en) begin
          quo_d = quo_step;
          rem_d = ge ? rem_sub[BaseW-1:0] : rem_shift[BaseW-1:0];
          if (cnt_q == CntLast) begin
            // Digit done: hand it to the output and restart on the quotient.
            out_valid_d = 1'b1;
            out_place_d = place_q;
            out_digit_d = ge ? rem_sub[BaseW-1:0] : rem_shift[BaseW-1:0];
            out_last_d  = (quo_step == '0);
            rem_d       = '0;
            cnt_d       = '0;
            place_d     = place_q + place_t'(1);
            if (quo_step == '0) begin
              state_d = StIdle;
            end
          end else begin
            cnt_d = cnt_q + CntW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold control state under reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Advance datapath and output payload registers.
  always_ff @(posedge clk_i) begin
    quo_q       <= quo_d;
    rem_q       <= rem_d;
    base_q      <= base_d;
    cnt_q       <= cnt_d;
    place_q     <= place_d;
    out_place_q <= out_place_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign place_o     = out_place_q;
  assign digit_o     = out_digit_q;
  assign last_o      = out_last_q;

endmodule

[tb/sv/tb_integer_to_radix_digits.sv]
// Testbench for integer_to_radix_digits: directed and random values, checked
// digit by digit against an in-bench repeated-division model.
// Depends on i2rd_pkg and the integer_to_radix_digits RTL.
`timescale 1ns / 1ps

module tb_integer_to_radix_digits;
  import i2rd_pkg::*;

  localparam int unsigned ValueBits = 31;
  localparam logic [ValueBits-1:0] ValueMax = '1;

  typedef struct packed {
    place_t place;
    base_t  digit;
    logic   last;
  } digit_rec_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [ValueBits-1:0] value_i;
  base_t                target_base_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  place_t               place_o;
  base_t                digit_o;
  logic                 last_o;

  digit_rec_t pending_digits[$];
  int unsigned mismatches = 0;
  // Suppress idling on both sides while set.
  bit steady_flow = 1'b0;

  integer_to_radix_digits #(
    .VALUE_BITS(ValueBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .value_i      (value_i),
    .target_base_i(target_base_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .place_o      (place_o),
    .digit_o      (digit_o),
    .last_o       (last_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Expand a value into its digits by repeated division, least significant first.
  function automatic void expand_digits(input logic [ValueBits-1:0] v, input base_t b);
    longint unsigned rest;
    int unsigned     radix;
    int unsigned     idx;
    digit_rec_t      rec;
    radix = 32'(b);
    if (b < BaseMin) radix = 32'(BaseMin);
    if (b > BaseMax) radix = 32'(BaseMax);
    rest = 64'(v);
    idx  = 0;
    do begin
      rec.digit = base_t'(rest % radix);
      rest      = rest / radix;
      rec.place = place_t'(idx);
      rec.last  = (rest == 0);
      pending_digits.push_back(rec);
      idx++;
    end while (rest != 0);
  endfunction

  // Send one transaction; return at the edge that accepts it, valid still high.
  task automatic send_value(input logic [ValueBits-1:0] v, input base_t b);
    if (!steady_flow && $urandom_range(99) < 9) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 100)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_i       <= v;
    target_base_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expand_digits(v, b);
  endtask

  // Receiver: drop ready now and then unless in a steady stretch.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow || ($urandom_range(99) >= 9);
  end

  // Compare each accepted digit with the oldest expectation.
  always @(posedge clk_i) begin
    digit_rec_t exp_rec;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digits.size() == 0) begin
        $error("unexpected digit: place %0d digit %0d last %0d", place_o, digit_o, last_o);
        mismatches++;
      end else begin
        exp_rec = pending_digits.pop_front();
        if (place_o !== exp_rec.place) begin
          $error("place: expected %0d, actual %0d", exp_rec.place, place_o);
          mismatches++;
        end
        if (digit_o !== exp_rec.digit) begin
          $error("digit: expected %0d, actual %0d", exp_rec.digit, digit_o);
          mismatches++;
        end
        if (last_o !== exp_rec.last) begin
          $error("last: expected %0d, actual %0d", exp_rec.last, last_o);
          mismatches++;
        end
      end
    end
  end

  // Zero, one, full-width values, maximal digits and inner zero digits.
  task automatic test_extremes();
    send_value('0, 6'd10);
    send_value('0, 6'd2);
    send_value('0, 6'd36);
    send_value(ValueBits'(1), 6'd2);
    send_value(ValueMax, 6'd2);
    send_value(ValueMax, 6'd36);
    send_value(ValueMax, 6'd10);
    send_value(ValueBits'(35), 6'd36);
    send_value(ValueBits'(60466175), 6'd36);
    send_value(ValueBits'(60466176), 6'd36);
    send_value(ValueBits'(1000), 6'd10);
    send_value(ValueBits'(1024), 6'd2);
    send_value(ValueBits'(255), 6'd16);
    send_value(ValueBits'(9), 6'd3);
    send_value(31'h2AAA_AAAA, 6'd2);
    send_value(31'h5555_5555, 6'd2);
  endtask

  // Bases outside 2..36 fold to the nearest limit.
  task automatic test_base_folding();
    send_value(ValueBits'(5), 6'd0);
    send_value(ValueMax, 6'd1);
    send_value(ValueBits'(100), 6'd37);
    send_value(ValueMax, 6'd63);
    send_value('0, 6'd63);
    send_value(ValueBits'(1295), 6'd40);
  endtask

  // Random values of varied magnitude, mostly legal bases.
  task automatic test_random(input int unsigned count);
    logic [ValueBits-1:0] v;
    base_t                b;
    repeat (count) begin
      v = ValueBits'($urandom >> $urandom_range(0, 31));
      if ($urandom_range(99) < 85) b = base_t'($urandom_range(BaseMin, BaseMax));
      else b = base_t'($urandom_range(0, 63));
      send_value(v, b);
    end
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_steady_stream(input int unsigned count);
    steady_flow = 1'b1;
    test_random(count);
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    target_base_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_base_folding();
    test_random(68);
    test_steady_stream(20);

    // Drain: wait for every expected digit, then leave a margin for any stray digit.
    in_valid_i <= 1'b0;
    while (pending_digits.size() != 0) @(posedge clk_i);
    repeat (2 * ValueBits) @(posedge clk_i);

    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("tb_integer_to_radix_digits passed");
    end else begin
      $display("tb_integer_to_radix_digits failed");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #10_000_000;
    $display("tb_integer_to_radix_digits failed");
    $finish;
  end

endmodule
